>>> hdl/pma_pkg.sv
// shared types and fixed-point constants of the polynomial moment accumulator
`default_nettype none
package pma_pkg;

  localparam int XW    = 16;  // Q1.15 sample width
  localparam int PW    = 33;  // x^k and term width, Q.31 with room for +1.0
  localparam int PRODW = 49;  // product of a power and a sample
  localparam int ACCW  = 48;  // Q16.31 accumulator
  localparam int RSH   = 15;  // Q.46 to Q.31

  localparam logic signed [PW-1:0]    ONE_Q31    = 33'sh080000000;
  localparam logic signed [PRODW-1:0] ROUND_HALF = 49'sd16384;
  localparam logic signed [ACCW-1:0]  ACC_MAX    = 48'sh7FFFFFFFFFFF;
  localparam logic signed [ACCW-1:0]  ACC_MIN    = 48'sh800000000000;

  localparam logic KIND_POWER = 1'b0;
  localparam logic KIND_CROSS = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RND  = 5'b00100,
    S_ACC  = 5'b01000,
    S_EMIT = 5'b10000
  } pma_state_t;

endpackage
`default_nettype wire

>>> hdl/polyfit_moment_accumulator.sv
// top level: least-squares moment accumulator with one shared multiplier
`default_nettype none
// Takes (x, y) samples in Q1.15 and keeps the normal-equation sums of a polynomial fit:
// power sums of x^k for k = 0..2*MAX_DEGREE (k = 0 counts samples as 1.0 each) and cross
// sums of y*x^l for l = 0..MAX_DEGREE, all saturating 48-bit Q16.31. A sample with tuser
// set starts a new set; a sample with tlast set makes the block send power sums 0..2D and
// then cross sums 0..D, with tlast on the final one. Each term for power k >= 2 or cross
// l >= 1 goes through one shared 33x16 multiplier, then every term goes through a rounding
// register and one saturating adder in turn. A last sample then has its results sent, one
// per cycle while out_tready is high. in_tready is low while a sample is worked on and while
// its results are sent.
module polyfit_moment_accumulator
  import pma_pkg::*;
#(
  parameter int MAX_DEGREE = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,    // degree
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // x_value [15:0], y_value [31:16]
  input  wire logic        in_tuser,    // first_sample
  input  wire logic        in_tlast,    // last_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // power_index [2:0], sum_value [50:3], zero fill
  output logic [1:0]       out_tuser,   // sum_kind [0], saturated [1]
  output logic             out_tlast    // last_result
);

  localparam int NPOW   = 2 * MAX_DEGREE + 1;
  localparam int NCROSS = MAX_DEGREE + 1;
  localparam int NACC   = NPOW + NCROSS;
  localparam int KW     = $clog2(NPOW);
  localparam int AW     = $clog2(NACC);
  localparam logic [KW-1:0] K_LAST  = KW'(NPOW - 1);
  localparam logic [KW-1:0] K_XLAST = KW'(NCROSS - 1);
  localparam logic [KW-1:0] K_MAXD  = KW'(MAX_DEGREE);
  localparam logic [KW-1:0] K_ONE   = KW'(1);
  localparam logic [KW-1:0] K_TWO   = KW'(2);

  pma_state_t state_r, state_nxt;

  logic [1:0]               degree_r;
  logic signed [XW-1:0]     x_r, y_r;
  logic                     last_r;
  logic                     clear_r, clear_nxt;   // treat stored sums as zero this sample
  logic                     clip_r, clip_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic                     cross_r, cross_nxt;
  logic signed [PW-1:0]     p_r, p_nxt;           // x^k after the power term of k
  logic signed [PRODW-1:0]  prod_r, prod_nxt;
  logic signed [PW-1:0]     term_r, term_nxt;
  logic [KW-1:0]            em_k_r, em_k_nxt;
  logic                     em_cross_r, em_cross_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_kind_r, out_sat_r, out_last_r;
  logic [2:0]               out_idx_r;
  logic signed [ACCW-1:0]   out_val_r;
  logic                     out_load;

  logic signed [ACCW-1:0]   acc_mem [NACC];
  logic [AW-1:0]            rd_addr;
  logic signed [ACCW-1:0]   acc_rd_r;             // read in the rounding cycle
  logic                     acc_we;
  logic signed [ACCW-1:0]   acc_wdata;

  logic [KW-1:0]            deg_eff;
  logic [KW-1:0]            deg_two;
  logic signed [PRODW-1:0]  rnd_sum;
  logic signed [XW-1:0]     mul_opnd;
  logic signed [ACCW-1:0]   acc_base;
  logic signed [ACCW:0]     acc_sum;
  logic                     next_cross;
  logic [KW-1:0]            next_k;
  logic                     ops_done;
  logic                     next_mul;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  // clamp the programmed degree into 1..MAX_DEGREE
  always_comb begin
    if (degree_r == 2'd0) begin
      deg_eff = K_ONE;
    end else if (int'(degree_r) > MAX_DEGREE) begin
      deg_eff = K_MAXD;
    end else begin
      deg_eff = KW'(degree_r);
    end
  end
  assign deg_two = deg_eff << 1;

  always_comb begin
    if (state_r == S_EMIT) begin
      rd_addr = em_cross_r ? (AW'(NPOW) + AW'(em_k_r)) : AW'(em_k_r);
    end else begin
      rd_addr = cross_r ? (AW'(NPOW) + AW'(k_r)) : AW'(k_r);
    end
  end

  assign mul_opnd = cross_r ? y_r : x_r;
  assign rnd_sum  = prod_r + ROUND_HALF;

  // saturating add of the current term
  assign acc_base = clear_r ? '0 : acc_rd_r;
  assign acc_sum  = {acc_base[ACCW-1], acc_base}
                  + {{(ACCW + 1 - PW){term_r[PW-1]}}, term_r};
  always_comb begin
    if (acc_sum[ACCW] != acc_sum[ACCW-1]) begin
      acc_wdata = acc_sum[ACCW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_wdata = acc_sum[ACCW-1:0];
    end
  end

  // term order: power k, then cross k while k has a cross sum
  always_comb begin
    ops_done   = 1'b0;
    next_cross = 1'b0;
    next_k     = k_r;
    if (!cross_r && (k_r <= K_XLAST)) begin
      next_cross = 1'b1;
    end else if (k_r == K_LAST) begin
      ops_done = 1'b1;
    end else begin
      next_k = k_r + K_ONE;
    end
    next_mul = next_cross ? (next_k != '0) : (next_k >= K_TWO);
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    clear_nxt     = clear_r;
    clip_nxt      = clip_r;
    k_nxt         = k_r;
    cross_nxt     = cross_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    term_nxt      = term_r;
    em_k_nxt      = em_k_r;
    em_cross_nxt  = em_cross_r;
    acc_we        = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          clear_nxt = clear_r | in_tuser;
          if (in_tuser) begin
            clip_nxt = 1'b0;
          end
          k_nxt     = '0;
          cross_nxt = KIND_POWER;
          state_nxt = S_RND;
        end
      end
      S_MUL: begin
        prod_nxt  = p_r * mul_opnd;
        state_nxt = S_RND;
      end
      S_RND: begin
        if (cross_r) begin
          term_nxt = (k_r == '0) ? PW'({y_r, 16'h0000}) : rnd_sum[RSH +: PW];
        end else if (k_r == '0) begin
          term_nxt = ONE_Q31;
        end else if (k_r == K_ONE) begin
          term_nxt = PW'({x_r, 16'h0000});
          p_nxt    = PW'({x_r, 16'h0000});
        end else begin
          term_nxt = rnd_sum[RSH +: PW];
          p_nxt    = rnd_sum[RSH +: PW];
        end
        if (cross_r && (k_r == '0)) begin
          term_nxt = {y_r[XW-1], y_r, 16'h0000};
        end
        if (!cross_r && (k_r == K_ONE)) begin
          term_nxt = {x_r[XW-1], x_r, 16'h0000};
          p_nxt    = {x_r[XW-1], x_r, 16'h0000};
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_we = 1'b1;
        if (acc_sum[ACCW] != acc_sum[ACCW-1]) begin
          clip_nxt = 1'b1;
        end
        if (ops_done) begin
          clear_nxt    = 1'b0;
          em_k_nxt     = '0;
          em_cross_nxt = KIND_POWER;
          state_nxt    = last_r ? S_EMIT : S_IDLE;
        end else begin
          k_nxt     = next_k;
          cross_nxt = next_cross;
          state_nxt = next_mul ? S_MUL : S_RND;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (!em_cross_r && (em_k_r == deg_two)) begin
            em_cross_nxt = KIND_CROSS;
            em_k_nxt     = '0;
          end else if (em_cross_r && (em_k_r == deg_eff)) begin
            state_nxt = S_IDLE;
          end else begin
            em_k_nxt = em_k_r + K_ONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      degree_r    <= 2'd1;
      clear_r     <= 1'b1;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_r     <= clear_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        degree_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cross_r    <= cross_nxt;
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    term_r     <= term_nxt;
    em_k_r     <= em_k_nxt;
    em_cross_r <= em_cross_nxt;
    if (in_tvalid && in_tready) begin
      x_r    <= in_tdata[15:0];
      y_r    <= in_tdata[31:16];
      last_r <= in_tlast;
    end
    if (out_load) begin
      out_kind_r <= em_cross_r;
      out_idx_r  <= 3'(em_k_r);
      out_val_r  <= acc_mem[rd_addr];
      out_sat_r  <= clip_r;
      out_last_r <= em_cross_r && (em_k_r == deg_eff);
    end
  end

  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem[rd_addr];
    if (acc_we) begin
      acc_mem[rd_addr] <= acc_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_val_r, out_idx_r};
  assign out_tuser  = {out_sat_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> bench/moment_sum_checker.sv
// watches the channels of the moment accumulator, predicts its sums and compares them
`timescale 1ns / 100ps
module moment_sum_checker
  import pma_pkg::*;
#(
  parameter int MAX_DEGREE = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,    // x_value [15:0], y_value [31:16]
  input  wire logic        in_tuser,    // first_sample
  input  wire logic        in_tlast,    // last_sample
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,   // power_index [2:0], sum_value [50:3], zero fill
  input  wire logic [1:0]  out_tuser,   // sum_kind [0], saturated [1]
  input  wire logic        out_tlast,   // last_result
  output int               mismatches,
  output int               sums_pending,
  output int               sums_checked
);

  localparam int NPOW   = 2 * MAX_DEGREE + 1;
  localparam int NCROSS = MAX_DEGREE + 1;

  typedef struct packed {
    logic                   kind;
    logic [2:0]             index;
    logic signed [ACCW-1:0] value;
    logic                   sat;
    logic                   last;
  } sum_rec_t;

  logic signed [ACCW-1:0] xk_sum  [0:NPOW-1];    // sum of x^k
  logic signed [ACCW-1:0] yxk_sum [0:NCROSS-1];  // sum of y*x^k
  logic                   clip_seen;
  logic [1:0]             fit_degree;
  sum_rec_t               sums_due [$];
  int                     error_cnt = 0;
  int                     checked_cnt = 0;
  sum_rec_t               got, want;

  function automatic logic signed [ACCW-1:0] sat_sum(input logic signed [ACCW-1:0] acc,
                                                     input longint term);
    longint s;
    s = longint'(acc) + term;
    if (s > longint'(ACC_MAX)) begin
      s = longint'(ACC_MAX);
      clip_seen = 1'b1;
    end else if (s < longint'(ACC_MIN)) begin
      s = longint'(ACC_MIN);
      clip_seen = 1'b1;
    end
    return s[ACCW-1:0];
  endfunction

  // q.46 product back to q.31, rounding half up
  function automatic longint round_q31(input longint prod);
    return (prod + 16384) >>> RSH;
  endfunction

  task automatic accumulate_sample(input logic [15:0] x_raw, input logic [15:0] y_raw,
                                   input logic first_s, input logic last_s);
    longint   xv, yv, xpow;
    int       k, d;
    sum_rec_t rec;
    xv = longint'($signed(x_raw));
    yv = longint'($signed(y_raw));
    xpow = 0;
    if (first_s) begin
      for (k = 0; k < NPOW; k++) xk_sum[k] = '0;
      for (k = 0; k < NCROSS; k++) yxk_sum[k] = '0;
      clip_seen = 1'b0;
    end
    // every accumulator runs whatever the degree
    for (k = 0; k < NPOW; k++) begin
      if (k == 0) xpow = longint'(ONE_Q31);
      else if (k == 1) xpow = xv * 65536;
      else xpow = round_q31(xpow * xv);
      xk_sum[k] = sat_sum(xk_sum[k], xpow);
      if (k < NCROSS)
        yxk_sum[k] = sat_sum(yxk_sum[k], (k == 0) ? yv * 65536 : round_q31(xpow * yv));
    end
    if (last_s) begin
      d = (fit_degree == 2'd0) ? 1 : int'(fit_degree);
      if (d > MAX_DEGREE) d = MAX_DEGREE;
      for (k = 0; k <= 2 * d; k++) begin
        rec.kind  = KIND_POWER;
        rec.index = k[2:0];
        rec.value = xk_sum[k];
        rec.sat   = clip_seen;
        rec.last  = 1'b0;
        sums_due.push_back(rec);
      end
      for (k = 0; k <= d; k++) begin
        rec.kind  = KIND_CROSS;
        rec.index = k[2:0];
        rec.value = yxk_sum[k];
        rec.sat   = clip_seen;
        rec.last  = (k == d);
        sums_due.push_back(rec);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NPOW; k++) xk_sum[k] = '0;
      for (int k = 0; k < NCROSS; k++) yxk_sum[k] = '0;
      clip_seen  = 1'b0;
      fit_degree = 2'd1;
      sums_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) fit_degree = cfg_data;
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser[0];
        got.sat   = out_tuser[1];
        got.index = out_tdata[2:0];
        got.value = out_tdata[50:3];
        got.last  = out_tlast;
        checked_cnt++;
        if (sums_due.size() == 0) begin
          $error("unexpected result transfer: kind %0d index %0d value %0d",
                 got.kind, got.index, got.value);
          error_cnt++;
        end else begin
          want = sums_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("sum_kind: expected %0d, got %0d", want.kind, got.kind);
            error_cnt++;
          end
          if (got.index !== want.index) begin
            $error("power_index: expected %0d, got %0d", want.index, got.index);
            error_cnt++;
          end
          if (got.value !== want.value) begin
            $error("sum_value: expected %0d, got %0d", want.value, got.value);
            error_cnt++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, got.sat);
            error_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, got.last);
            error_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        accumulate_sample(in_tdata[15:0], in_tdata[31:16], in_tuser, in_tlast);
    end
    mismatches   <= error_cnt;
    sums_pending <= sums_due.size();
    sums_checked <= checked_cnt;
  end

endmodule

>>> bench/tb_top.sv
// testbench top: clock, reset, sample and degree stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module tb_top;

  localparam int  RANDOM_ITEMS  = 230;
  localparam int  SETTLE_CYCLES = 40;     // outlasts one non-emitting sample
  localparam int  HOLD_CYCLES   = 400;
  localparam int  TAIL_CYCLES   = 60;
  localparam longint LIMIT      = 6000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // x_value [15:0], y_value [31:16]
  logic        in_tuser = 1'b0;   // first_sample
  logic        in_tlast = 1'b0;   // last_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // power_index [2:0], sum_value [50:3], zero fill
  logic [1:0]  out_tuser;         // sum_kind [0], saturated [1]
  logic        out_tlast;         // last_result

  int     mismatches, sums_pending, sums_checked;
  int     samples_sent = 0;
  int     sets_closed = 0;
  int     degree_writes = 0;
  bit     steady = 1'b0;
  bit     hold_request = 1'b0;
  int     hold_left = 0;
  int     stall_left = 0;
  longint cycles = 0;

  polyfit_moment_accumulator #(.MAX_DEGREE(3)) dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  moment_sum_checker #(.MAX_DEGREE(3)) sum_check (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .mismatches, .sums_pending, .sums_checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d sums still due", cycles, sums_pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return r[15:0];
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off counted here
  initial forever begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic first_s, input logic last_s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= first_s;
    in_tlast  <= last_s;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    if (last_s) sets_closed++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0);
  endtask

  task automatic set_degree(input logic [1:0] d);
    wait_drained();
    // a sample without last may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    degree_writes++;
  endtask

  initial begin
    int  n, set_no, len, i;
    bit  broken;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes at reset degree, first and last together, carry-over sets
    send_sample(16'h8000, 16'h8000, 1'b1, 1'b1);
    set_degree(2'd3);
    send_sample(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    send_sample(16'h7FFF, 16'h8000, 1'b1, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 16'h0001, 1'b0, 1'b1);
    send_sample(16'h0001, 16'hFFFF, 1'b0, 1'b1);
    set_degree(2'd2);
    send_sample(16'h4000, 16'hC000, 1'b1, 1'b1);
    set_degree(2'd0);   // degree zero behaves as one
    send_sample(16'hC000, 16'h3039, 1'b1, 1'b0);
    set_degree(2'd3);   // degree change in the middle of a set
    send_sample(16'h5555, 16'hAAAA, 1'b0, 1'b1);
    set_degree(2'd1);
    send_sample(16'hAAAA, 16'h5555, 1'b1, 1'b0);
    send_sample(16'h8001, 16'h7FFE, 1'b0, 1'b1);

    // random sets, mostly well formed, some with scrambled flags
    n = 0;
    set_no = 0;
    while (n < RANDOM_ITEMS) begin
      if (set_no % 6 == 5) set_degree(2'($urandom_range(0, 3)));
      if (set_no == 14) steady = 1'b1;
      if (set_no == 18) steady = 1'b0;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      // the set before the long hold-off always closes so the block has sums to send
      broken = (set_no != 8) && ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
        if (broken)
          send_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        else
          send_sample(pick_sample(), pick_sample(),
                      i == 0 && $urandom_range(0, 9) != 0, i == len - 1);
        n++;
      end
      // block is busy emitting while the receiver holds off and the next set waits
      if (set_no == 8) hold_request = 1'b1;
      if (set_no == 24) wait_drained();
      set_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d samples closing %0d sets, checked %0d sums, %0d degree writes",
             samples_sent, sets_closed, sums_checked, degree_writes);
    $display("included full-scale samples, degree changes mid-set, scrambled flags "
             , "and a long output stall");
    if (mismatches == 0 && sums_pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
